// File: rtl/core/sha1_stream_hasher_defines.svh
`ifndef SHA1_STREAM_HASHER_DEFINES_SVH
`define SHA1_STREAM_HASHER_DEFINES_SVH

// same-cycle implication, held off during reset
`define SHA1SH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define SHA1SH_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/sha1sh_pkg.sv
`default_nettype none

package sha1sh_pkg;

    localparam int FILL_W   = 6;
    localparam int ROUND_W  = 7;
    localparam int ROUNDS   = 80;
    localparam int TOTAL_W  = 61;
    localparam int SCHED_W  = 512;
    localparam int OCNT_W   = 3;

    // byte source for the schedule shifter
    localparam logic [1:0] SEL_IN  = 2'd0;
    localparam logic [1:0] SEL_80  = 2'd1;
    localparam logic [1:0] SEL_00  = 2'd2;
    localparam logic [1:0] SEL_LEN = 2'd3;

    localparam logic [31:0] K_CONST [4] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };

    localparam logic [31:0] H_INIT [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    typedef struct packed {
        logic       shift_byte;
        logic [1:0] byte_sel;
        logic [2:0] len_sel;
        logic       count_byte;
        logic       init_work;
        logic       round;
        logic [1:0] phase;
        logic       add;
        logic       capture;
    } t_cmd;

    typedef struct packed {
        logic dig_busy;
    } t_status;

endpackage

`default_nettype wire

// File: rtl/core/sha1sh_datapath.sv
`default_nettype none

module sha1sh_datapath (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  sha1sh_pkg::t_cmd    i_cmd,
    input  wire  [7:0]          i_byte,
    output sha1sh_pkg::t_status o_status,
    output logic                o_m_tvalid,
    input  wire                 i_m_tready,
    output logic [31:0]         o_m_tdata,   // digest_word[31:0]
    output logic                o_m_tlast    // digest_last
);
    import sha1sh_pkg::*;

    logic [SCHED_W-1:0]  r_sched;
    logic [31:0]         r_h [5];
    logic [31:0]         r_w [5];
    logic [TOTAL_W-1:0]  r_total;
    logic [159:0]        r_dig;
    logic [OCNT_W-1:0]   r_cnt;

    logic [63:0] len_bits;
    logic [7:0]  len_bytes [8];
    logic [7:0]  push_byte;
    logic [31:0] w0, w2, w8, w13, w_new, f_val, t_val;
    logic        out_fire;

    assign len_bits = {r_total, 3'b000};

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            len_bytes[k] = len_bits[(7 - k) * 8 +: 8];
        end
    end

    always_comb begin
        case (i_cmd.byte_sel)
            SEL_IN:  push_byte = i_byte;
            SEL_80:  push_byte = 8'h80;
            SEL_00:  push_byte = 8'h00;
            SEL_LEN: push_byte = len_bytes[i_cmd.len_sel];
            default: push_byte = 8'h00;
        endcase
    end

    // window holds W[t..t+15], W[t] in the top word
    assign w0    = r_sched[511:480];
    assign w2    = r_sched[447:416];
    assign w8    = r_sched[255:224];
    assign w13   = r_sched[95:64];
    assign w_new = {(w13[30:0] ^ w8[30:0] ^ w2[30:0] ^ w0[30:0]),
                    (w13[31] ^ w8[31] ^ w2[31] ^ w0[31])};

    always_comb begin
        case (i_cmd.phase)
            2'd0:    f_val = (r_w[1] & r_w[2]) | (~r_w[1] & r_w[3]);
            2'd2:    f_val = (r_w[1] & r_w[2]) | (r_w[1] & r_w[3]) | (r_w[2] & r_w[3]);
            default: f_val = r_w[1] ^ r_w[2] ^ r_w[3];
        endcase
    end

    assign t_val = {r_w[0][26:0], r_w[0][31:27]} + f_val + r_w[4] + w0
                 + K_CONST[i_cmd.phase];

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_byte) begin
            r_sched <= {r_sched[SCHED_W-9:0], push_byte};
        end else if (i_cmd.round) begin
            r_sched <= {r_sched[SCHED_W-33:0], w_new};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 5; k++) begin
                r_h[k] <= H_INIT[k];
                r_w[k] <= '0;
            end
            r_total <= '0;
        end else begin
            if (i_cmd.count_byte) begin
                r_total <= r_total + TOTAL_W'(1);
            end
            if (i_cmd.init_work) begin
                for (int k = 0; k < 5; k++) begin
                    r_w[k] <= r_h[k];
                end
            end else if (i_cmd.round) begin
                r_w[0] <= t_val;
                r_w[1] <= r_w[0];
                r_w[2] <= {r_w[1][1:0], r_w[1][31:2]};
                r_w[3] <= r_w[2];
                r_w[4] <= r_w[3];
            end
            if (i_cmd.add) begin
                for (int k = 0; k < 5; k++) begin
                    r_h[k] <= r_h[k] + r_w[k];
                end
            end else if (i_cmd.capture) begin
                for (int k = 0; k < 5; k++) begin
                    r_h[k] <= H_INIT[k];
                end
                r_total <= '0;
            end
        end
    end

    assign out_fire = o_m_tvalid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_dig <= {r_h[0], r_h[1], r_h[2], r_h[3], r_h[4]};
        end else if (out_fire) begin
            r_dig <= {r_dig[127:0], 32'h0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.capture) begin
            r_cnt <= OCNT_W'(5);
        end else if (out_fire) begin
            r_cnt <= r_cnt - OCNT_W'(1);
        end
    end

    assign o_m_tvalid        = (r_cnt != '0);
    assign o_m_tdata         = r_dig[159:128];
    assign o_m_tlast         = (r_cnt == OCNT_W'(1));
    assign o_status.dig_busy = (r_cnt != '0);

endmodule

`default_nettype wire

// File: rtl/core/sha1sh_ctrl.sv
`default_nettype none
`include "sha1_stream_hasher_defines.svh"

module sha1sh_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_s_tvalid,
    output logic                o_s_tready,
    input  wire                 i_byte_valid,
    input  wire                 i_eom,
    input  sha1sh_pkg::t_status i_status,
    output sha1sh_pkg::t_cmd    o_cmd
);
    import sha1sh_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic [ROUND_W-1:0] r_round, n_round;
    logic               r_sent80, n_sent80;
    logic               r_lenph, n_lenph;
    logic               r_pad, n_pad;
    logic               r_final, n_final;
    logic               len_now;

    // length bytes go in at offsets 56..63 of the last block
    assign len_now = r_sent80 && (r_lenph || (r_fill == FILL_W'(56)));

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_round  = r_round;
        n_sent80 = r_sent80;
        n_lenph  = r_lenph;
        n_pad    = r_pad;
        n_final  = r_final;
        o_cmd    = '0;
        if (r_round < ROUND_W'(20)) begin
            o_cmd.phase = 2'd0;
        end else if (r_round < ROUND_W'(40)) begin
            o_cmd.phase = 2'd1;
        end else if (r_round < ROUND_W'(60)) begin
            o_cmd.phase = 2'd2;
        end else begin
            o_cmd.phase = 2'd3;
        end
        o_s_tready = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    if (i_byte_valid) begin
                        o_cmd.shift_byte = 1'b1;
                        o_cmd.byte_sel   = SEL_IN;
                        o_cmd.count_byte = 1'b1;
                        n_fill           = r_fill + FILL_W'(1);
                        if (r_fill == FILL_W'(63)) begin
                            o_cmd.init_work = 1'b1;
                            n_round         = '0;
                            n_pad           = i_eom;
                            n_final         = 1'b0;
                            n_state         = S_ROUND;
                        end else if (i_eom) begin
                            n_state = S_PAD;
                        end
                    end else if (i_eom) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                o_cmd.shift_byte = 1'b1;
                n_fill           = r_fill + FILL_W'(1);
                if (!r_sent80) begin
                    o_cmd.byte_sel = SEL_80;
                    n_sent80       = 1'b1;
                end else if (len_now) begin
                    o_cmd.byte_sel = SEL_LEN;
                    o_cmd.len_sel  = r_fill[2:0];
                    n_lenph        = 1'b1;
                end else begin
                    o_cmd.byte_sel = SEL_00;
                end
                if (r_fill == FILL_W'(63)) begin
                    o_cmd.init_work = 1'b1;
                    n_round         = '0;
                    n_pad           = 1'b1;
                    n_final         = r_sent80 && len_now;
                    n_state         = S_ROUND;
                end
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_round     = r_round + ROUND_W'(1);
                if (r_round == ROUND_W'(ROUNDS - 1)) begin
                    n_round = '0;
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                if (r_final) begin
                    n_state = S_DONE;
                end else if (r_pad) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DONE: begin
                // wait until the previous digest has drained
                if (!i_status.dig_busy) begin
                    o_cmd.capture = 1'b1;
                    n_fill        = '0;
                    n_sent80      = 1'b0;
                    n_lenph       = 1'b0;
                    n_pad         = 1'b0;
                    n_final       = 1'b0;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_round  <= '0;
            r_sent80 <= 1'b0;
            r_lenph  <= 1'b0;
            r_pad    <= 1'b0;
            r_final  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_round  <= n_round;
            r_sent80 <= n_sent80;
            r_lenph  <= n_lenph;
            r_pad    <= n_pad;
            r_final  <= n_final;
        end
    end

    `SHA1SH_ASSERT_NXT(a_final_to_done, i_clk, i_rst_n, (r_state == S_ADD) && r_final, r_state == S_DONE, "final compression did not lead to digest capture")
    `SHA1SH_ASSERT_IMP(a_capture_free, i_clk, i_rst_n, o_cmd.capture, !i_status.dig_busy, "digest captured over an undrained digest")
    `SHA1SH_ASSERT_NXT(a_round_start, i_clk, i_rst_n, o_cmd.init_work, (r_state == S_ROUND) && (r_round == '0) && (r_fill == '0), "compression started off a block boundary")
    `SHA1SH_ASSERT_IMP(a_final_len, i_clk, i_rst_n, r_final && (r_state == S_ROUND), r_sent80 && r_lenph, "final block without padding and length")

endmodule

`default_nettype wire

// File: rtl/core/sha1_stream_hasher.sv
// SHA-1 over a byte stream.
// Input channel (s_axis): tdata[7:0] is the message byte, tuser says the byte is
// present, tlast marks the final item of a message. An item with tuser low and
// tlast high ends the message without adding a byte.
// Output channel (m_axis): five items per message, digest words A, B, C, D, E in
// tdata[31:0]; tlast is high on E.
// Block flow: the 64th byte of a block starts an 80-round compression at one
// round per cycle, followed by the chaining add. tready is low during the
// compression.
// Message end: padding is shifted in one byte per cycle up to the block end,
// then compressed; this takes one or two blocks, and the last compression is
// followed by the digest capture.
// The digest sits in its own output register, so the next message can be taken
// while the receiver stalls; only a second message end waits until all five
// words of the previous digest are taken.
// Reset (i_rst_n low, synchronous) loads the initial chaining values, clears the
// byte count and drops any pending digest.
`default_nettype none

module sha1_stream_hasher (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // msg_byte[7:0]
    input  wire         s_axis_tuser,   // byte_valid
    input  wire         s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word[31:0]
    output logic        m_axis_tlast    // digest_last
);
    import sha1sh_pkg::*;

    t_cmd    cmd;
    t_status status;

    sha1sh_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .o_s_tready   (s_axis_tready),
        .i_byte_valid (s_axis_tuser),
        .i_eom        (s_axis_tlast),
        .i_status     (status),
        .o_cmd        (cmd)
    );

    sha1sh_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_byte     (s_axis_tdata),
        .o_status   (status),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire
